// ===== design/mtc_pkg.sv =====
// Shared types and constants for the markdown token classifier.
// Holds the request structs, token kind codes, character codes and the
// command and status structs between the controller and the datapath.
package mtc_pkg;

  localparam int MAX_DIGITS = 8;
  localparam int CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int PH_W = (MAX_DIGITS > 2) ? CNT_W : 2;

  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_DASH = 8'h2D;
  localparam logic [7:0] CH_BANG = 8'h21;
  localparam logic [7:0] CH_LBRK = 8'h5B;
  localparam logic [7:0] CH_LPAR = 8'h28;
  localparam logic [7:0] CH_RPAR = 8'h29;
  localparam logic [7:0] CH_RBRK = 8'h5D;
  localparam logic [7:0] CH_TICK = 8'h60;
  localparam logic [7:0] CH_DOT = 8'h2E;
  localparam logic [7:0] CH_NL = 8'h0A;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  localparam logic [3:0] K_TEXT = 4'd0;
  localparam logic [3:0] K_LINEBREAK = 4'd1;
  localparam logic [3:0] K_BOLD = 4'd2;
  localparam logic [3:0] K_ITALIC = 4'd3;
  localparam logic [3:0] K_HEADING = 4'd4;
  localparam logic [3:0] K_UL = 4'd5;
  localparam logic [3:0] K_OL = 4'd6;
  localparam logic [3:0] K_IMAGE = 4'd7;
  localparam logic [3:0] K_LBRK = 4'd8;
  localparam logic [3:0] K_LPAR = 4'd9;
  localparam logic [3:0] K_RPAR = 4'd10;
  localparam logic [3:0] K_RBRK = 4'd11;
  localparam logic [3:0] K_FENCE = 4'd12;

  typedef struct packed {
    logic [7:0] src_byte;
    logic       end_of_source;
  } in_item_t;

  typedef struct packed {
    logic [3:0] token_kind;
    logic [7:0] token_byte;
    logic       token_start;
    logic       run_last;
  } out_item_t;

  typedef enum logic [2:0] {
    IT_NONE,
    IT_ITALIC,
    IT_BOLD,
    IT_FENCE,
    IT_TICKS,
    IT_DIGITS
  } item_t;

  typedef enum logic [1:0] {
    PH_NONE,
    PH_PRE,
    PH_MID,
    PH_SUF
  } phase_t;

  typedef struct packed {
    logic   load;
    logic   emit;
    phase_t phase;
    logic   idx_clr;
    logic   last;
  } ctl_cmd_t;

  typedef struct packed {
    logic [PH_W-1:0] pre_n;
    logic            mid_v;
    logic [PH_W-1:0] suf_n;
    logic [PH_W-1:0] idx;
    logic            out_free;
  } dp_status_t;

endpackage

// ===== design/markdown_token_classifier_core.sv =====
// Top level of the markdown token classifier.
// Joins mtc_ctrl and mtc_datapath; depends on mtc_pkg.
//
// Source bytes enter one request at a time and leave as result requests tagged with a
// token kind, a start mark and a last-of-byte mark. A byte is accepted in S_IDLE, and
// its prefix, middle and suffix results, from 0 to 9 of them, are then issued from
// S_PRE, S_MID and S_SUF. The controller hands these results through the single output
// register one per cycle while out_stall does not hold it, and takes no new byte meanwhile.
// The next byte is accepted in the cycle after the last result is loaded, even while
// that result still waits on out_stall.
module markdown_token_classifier_core import mtc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  ctl_cmd_t   cmd;
  dp_status_t status;

  mtc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  mtc_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== design/mtc_ctrl.sv =====
// Controller of the markdown token classifier.
// Sequences the prefix, middle and suffix results of one request.
// Depends on mtc_pkg for the command and status structs.
module mtc_ctrl import mtc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  dp_status_t status,
  output ctl_cmd_t   cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_PRE  = 4'b0010,
    S_MID  = 4'b0100,
    S_SUF  = 4'b1000
  } state_t;

  state_t          state_r, state_nxt, after_st;
  phase_t          eff;
  logic            pre_ne, suf_ne, plast, later;
  logic [PH_W-1:0] idx_inc;

  assign pre_ne  = (status.pre_n != '0);
  assign suf_ne  = (status.suf_n != '0);
  assign idx_inc = status.idx + PH_W'(1);

  always_comb begin
    eff = PH_NONE;
    case (state_r)
      S_PRE: begin
        if (pre_ne) eff = PH_PRE;
        else if (status.mid_v) eff = PH_MID;
        else if (suf_ne) eff = PH_SUF;
      end
      S_MID: begin
        if (status.mid_v) eff = PH_MID;
        else if (suf_ne) eff = PH_SUF;
      end
      S_SUF: begin
        if (suf_ne) eff = PH_SUF;
      end
      default: eff = PH_NONE;
    endcase
  end

  always_comb begin
    plast    = 1'b1;
    later    = 1'b0;
    after_st = S_IDLE;
    case (eff)
      PH_PRE: begin
        plast    = (idx_inc == status.pre_n);
        later    = status.mid_v || suf_ne;
        after_st = status.mid_v ? S_MID : S_SUF;
      end
      PH_MID: begin
        later    = suf_ne;
        after_st = S_SUF;
      end
      PH_SUF: begin
        plast = (idx_inc == status.suf_n);
      end
      default: plast = 1'b1;
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    in_stall    = 1'b1;
    cmd.load    = 1'b0;
    cmd.emit    = 1'b0;
    cmd.phase   = eff;
    cmd.idx_clr = plast;
    cmd.last    = plast && !later;
    if (state_r == S_IDLE) begin
      in_stall = 1'b0;
      cmd.load = in_valid;
      if (in_valid) state_nxt = S_PRE;
    end else if (eff == PH_NONE) begin
      state_nxt = S_IDLE;
    end else if (status.out_free) begin
      cmd.emit = 1'b1;
      if (plast) state_nxt = later ? after_st : S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> status.out_free) else $error("result issued into a full output register");
  a_load_pre: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == S_PRE) else $error("accepted request did not start sequencing");
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && cmd.last) |=> state_r == S_IDLE) else $error("final result did not end request");
`endif

endmodule

// ===== design/mtc_datapath.sv =====
// Datapath of the markdown token classifier.
// Holds the lexer state, digit buffer, result plan and output register.
// Depends on mtc_pkg for types, character codes and token kinds.
module mtc_datapath import mtc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  ctl_cmd_t   cmd,
  input  in_item_t   in_data,
  output dp_status_t status,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data
);

  typedef enum logic [6:0] {
    L_FRESH   = 7'b0000001,
    L_TEXT    = 7'b0000010,
    L_STAR    = 7'b0000100,
    L_TICK1   = 7'b0001000,
    L_TICK2   = 7'b0010000,
    L_DIGIT   = 7'b0100000,
    L_LONGDIG = 7'b1000000
  } lex_mode_t;

  lex_mode_t       lex_mode_r, lex_mode_nxt, bt_mode;
  logic            code_mode_r, code_mode_nxt;
  logic [CNT_W-1:0] digit_count_r, digit_count_nxt, cnt_after;
  logic [7:0]      digit_store_r [MAX_DIGITS];
  item_t           pre_type_r, pre_type_nxt, suf_type_r, suf_type_nxt, sel_type;
  logic [PH_W-1:0] pre_n_r, pre_n_nxt, suf_n_r, suf_n_nxt, idx_r;
  logic [3:0]      fl_kind_r, fl_kind_nxt, mid_kind_r, mid_kind_nxt, bt_kind;
  logic            mid_v_r, mid_v_nxt, mid_start_r, mid_start_nxt;
  logic [7:0]      mid_byte_r, c;
  logic            out_valid_r;
  out_item_t       out_data_r, item;
  logic            wr_en;
  logic [IDX_W-1:0] wr_idx;
  logic            is_dig, ends, bt_v, bt_dig, use_bt, use_ct;

  assign c      = in_data.src_byte;
  assign is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
  assign ends   = (c == CH_NL) || (!code_mode_r && ((c == CH_STAR) || (c == CH_LBRK) ||
                  (c == CH_RBRK) || (c == CH_LPAR) || (c == CH_RPAR)));

  always_comb begin
    bt_mode = L_TEXT;
    bt_v    = 1'b1;
    bt_kind = K_TEXT;
    bt_dig  = 1'b0;
    if (c == CH_NL) begin
      bt_mode = L_FRESH;
      bt_kind = K_LINEBREAK;
    end else if (!code_mode_r && c == CH_STAR) begin
      bt_mode = L_STAR;
      bt_v    = 1'b0;
    end else if (!code_mode_r && c == CH_HASH) begin
      bt_mode = L_FRESH;
      bt_kind = K_HEADING;
    end else if (!code_mode_r && c == CH_DASH) begin
      bt_mode = L_FRESH;
      bt_kind = K_UL;
    end else if (!code_mode_r && c == CH_BANG) begin
      bt_mode = L_FRESH;
      bt_kind = K_IMAGE;
    end else if (!code_mode_r && c == CH_LBRK) begin
      bt_mode = L_FRESH;
      bt_kind = K_LBRK;
    end else if (!code_mode_r && c == CH_LPAR) begin
      bt_mode = L_FRESH;
      bt_kind = K_LPAR;
    end else if (!code_mode_r && c == CH_RPAR) begin
      bt_mode = L_FRESH;
      bt_kind = K_RPAR;
    end else if (!code_mode_r && c == CH_RBRK) begin
      bt_mode = L_FRESH;
      bt_kind = K_RBRK;
    end else if (!code_mode_r && is_dig) begin
      bt_mode = L_DIGIT;
      bt_v    = 1'b0;
      bt_dig  = 1'b1;
    end else if (c == CH_TICK) begin
      bt_mode = L_TICK1;
      bt_v    = 1'b0;
    end
  end

  always_comb begin
    lex_mode_nxt    = lex_mode_r;
    code_mode_nxt   = code_mode_r;
    digit_count_nxt = digit_count_r;
    pre_type_nxt    = IT_NONE;
    pre_n_nxt       = '0;
    suf_type_nxt    = IT_NONE;
    suf_n_nxt       = '0;
    fl_kind_nxt     = K_TEXT;
    mid_v_nxt       = 1'b0;
    mid_kind_nxt    = K_TEXT;
    mid_start_nxt   = 1'b0;
    wr_en           = 1'b0;
    wr_idx          = '0;
    use_bt          = 1'b0;
    use_ct          = 1'b0;
    cnt_after       = '0;
    case (lex_mode_r)
      L_TEXT: begin
        use_ct = 1'b1;
      end
      L_STAR: begin
        if (c == CH_STAR) begin
          pre_type_nxt = IT_BOLD;
          pre_n_nxt    = PH_W'(1);
          lex_mode_nxt = L_FRESH;
        end else begin
          pre_type_nxt = IT_ITALIC;
          pre_n_nxt    = PH_W'(1);
          use_bt       = 1'b1;
        end
      end
      L_TICK1: begin
        if (c == CH_TICK) begin
          lex_mode_nxt = L_TICK2;
        end else begin
          pre_type_nxt = IT_TICKS;
          pre_n_nxt    = PH_W'(1);
          use_ct       = 1'b1;
        end
      end
      L_TICK2: begin
        if (c == CH_TICK) begin
          pre_type_nxt  = IT_FENCE;
          pre_n_nxt     = PH_W'(1);
          code_mode_nxt = !code_mode_r;
          lex_mode_nxt  = L_FRESH;
        end else begin
          pre_type_nxt = IT_TICKS;
          pre_n_nxt    = PH_W'(2);
          use_ct       = 1'b1;
        end
      end
      L_DIGIT: begin
        if (is_dig && digit_count_r < CNT_W'(MAX_DIGITS)) begin
          wr_en           = 1'b1;
          wr_idx          = digit_count_r[IDX_W-1:0];
          digit_count_nxt = digit_count_r + CNT_W'(1);
        end else begin
          pre_type_nxt    = IT_DIGITS;
          pre_n_nxt       = PH_W'(digit_count_r);
          digit_count_nxt = '0;
          if (is_dig) begin
            mid_v_nxt    = 1'b1;
            lex_mode_nxt = L_LONGDIG;
          end else if (c == CH_DOT) begin
            fl_kind_nxt  = K_OL;
            lex_mode_nxt = L_FRESH;
          end else begin
            use_bt = 1'b1;
          end
        end
      end
      L_LONGDIG: begin
        if (is_dig) mid_v_nxt = 1'b1;
        else use_bt = 1'b1;
      end
      default: begin
        use_bt = 1'b1;
      end
    endcase
    if (use_ct) begin
      if (ends) begin
        use_bt = 1'b1;
      end else begin
        mid_v_nxt    = 1'b1;
        lex_mode_nxt = L_TEXT;
      end
    end
    if (use_bt) begin
      lex_mode_nxt  = bt_mode;
      mid_v_nxt     = bt_v;
      mid_kind_nxt  = bt_kind;
      mid_start_nxt = 1'b1;
      if (bt_dig) begin
        wr_en           = 1'b1;
        wr_idx          = '0;
        digit_count_nxt = CNT_W'(1);
      end
    end
    if (in_data.end_of_source) begin
      cnt_after = digit_count_nxt;
      case (lex_mode_nxt)
        L_STAR: begin
          suf_type_nxt = IT_ITALIC;
          suf_n_nxt    = PH_W'(1);
        end
        L_TICK1: begin
          suf_type_nxt = IT_TICKS;
          suf_n_nxt    = PH_W'(1);
        end
        L_TICK2: begin
          suf_type_nxt = IT_TICKS;
          suf_n_nxt    = PH_W'(2);
        end
        L_DIGIT: begin
          suf_type_nxt = IT_DIGITS;
          suf_n_nxt    = PH_W'(cnt_after);
        end
        default: suf_type_nxt = IT_NONE;
      endcase
      lex_mode_nxt    = L_FRESH;
      code_mode_nxt   = 1'b0;
      digit_count_nxt = '0;
    end
  end

  always_comb begin
    sel_type = IT_NONE;
    case (cmd.phase)
      PH_PRE:  sel_type = pre_type_r;
      PH_SUF:  sel_type = suf_type_r;
      default: sel_type = IT_NONE;
    endcase
    item.token_kind  = K_TEXT;
    item.token_byte  = CH_STAR;
    item.token_start = 1'b1;
    item.run_last    = cmd.last;
    if (cmd.phase == PH_MID) begin
      item.token_kind  = mid_kind_r;
      item.token_byte  = mid_byte_r;
      item.token_start = mid_start_r;
    end else begin
      case (sel_type)
        IT_ITALIC: item.token_kind = K_ITALIC;
        IT_BOLD:   item.token_kind = K_BOLD;
        IT_FENCE: begin
          item.token_kind = K_FENCE;
          item.token_byte = CH_TICK;
        end
        IT_TICKS: begin
          item.token_byte  = CH_TICK;
          item.token_start = (idx_r == '0);
        end
        IT_DIGITS: begin
          item.token_kind  = fl_kind_r;
          item.token_byte  = digit_store_r[idx_r[IDX_W-1:0]];
          item.token_start = (idx_r == '0);
        end
        default: item.token_kind = K_TEXT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && wr_en) digit_store_r[wr_idx] <= c;
    if (cmd.load) begin
      mid_byte_r  <= c;
      mid_kind_r  <= mid_kind_nxt;
      mid_start_r <= mid_start_nxt;
      fl_kind_r   <= fl_kind_nxt;
      pre_type_r  <= pre_type_nxt;
      suf_type_r  <= suf_type_nxt;
    end
    if (cmd.emit) out_data_r <= item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lex_mode_r    <= L_FRESH;
      code_mode_r   <= 1'b0;
      digit_count_r <= '0;
      pre_n_r       <= '0;
      suf_n_r       <= '0;
      mid_v_r       <= 1'b0;
      idx_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cmd.load) begin
        lex_mode_r    <= lex_mode_nxt;
        code_mode_r   <= code_mode_nxt;
        digit_count_r <= digit_count_nxt;
        pre_n_r       <= pre_n_nxt;
        suf_n_r       <= suf_n_nxt;
        mid_v_r       <= mid_v_nxt;
        idx_r         <= '0;
      end else if (cmd.emit) begin
        idx_r <= cmd.idx_clr ? '0 : idx_r + PH_W'(1);
      end
      if (cmd.emit) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  assign status.pre_n    = pre_n_r;
  assign status.mid_v    = mid_v_r;
  assign status.suf_n    = suf_n_r;
  assign status.idx      = idx_r;
  assign status.out_free = !out_valid_r || !out_stall;
  assign out_valid       = out_valid_r;
  assign out_data        = out_data_r;

`ifndef ASSERT_OFF
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    digit_count_r <= CNT_W'(MAX_DIGITS)) else $error("digit count beyond buffer depth");
  a_eos_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load && in_data.end_of_source) |=>
      (lex_mode_r == L_FRESH && !code_mode_r && digit_count_r == '0))
    else $error("end of source did not clear lexer state");
`endif

endmodule

// ===== verif/tb_markdown_token_classifier_core.sv =====
// Self-checking testbench for markdown_token_classifier_core.
// Feeds directed and random source bytes, predicts the token stream in place and
// compares every result; depends on mtc_pkg and the core RTL.
module tb_markdown_token_classifier_core;
  timeunit 1ns;
  timeprecision 1ps;
  import mtc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  typedef enum logic [2:0] {
    LX_FRESH,
    LX_TEXT,
    LX_STAR,
    LX_TICK1,
    LX_TICK2,
    LX_DIGIT,
    LX_LONG
  } lex_t;

  typedef struct packed {
    in_item_t  req;
    logic      typed;
    out_item_t want;
  } row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  row_t      cur_row = '0;
  row_t      plan_q[$];
  out_item_t step_q[$];
  out_item_t token_q[$];
  out_item_t want;
  out_item_t tok;

  lex_t       lex = LX_FRESH;
  logic       code_on = 1'b0;
  logic [7:0] dig_buf [MAX_DIGITS];
  int         dig_cnt = 0;

  logic [7:0] marks [7] = '{CH_HASH, CH_DASH, CH_BANG, CH_LBRK, CH_RBRK, CH_LPAR, CH_RPAR};

  int cycles = 0;
  int mismatches = 0;
  int src_bytes = 0;
  int sources_ended = 0;
  int tokens_seen = 0;
  int stall_pct = 71;

  markdown_token_classifier_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void put_token(logic [3:0] k, logic [7:0] b, logic st);
    out_item_t t;
    t.token_kind = k;
    t.token_byte = b;
    t.token_start = st;
    t.run_last = 1'b0;
    step_q.push_back(t);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic void flush_digits(logic [3:0] k);
    for (int i = 0; i < dig_cnt; i++) put_token(k, dig_buf[i], i == 0);
    dig_cnt = 0;
  endfunction

  function automatic void open_token(logic [7:0] c);
    lex = LX_FRESH;
    if (c == CH_NL) begin
      put_token(K_LINEBREAK, c, 1'b1);
      return;
    end
    if (!code_on) begin
      case (c)
        CH_STAR: begin
          lex = LX_STAR;
          return;
        end
        CH_HASH: begin
          put_token(K_HEADING, c, 1'b1);
          return;
        end
        CH_DASH: begin
          put_token(K_UL, c, 1'b1);
          return;
        end
        CH_BANG: begin
          put_token(K_IMAGE, c, 1'b1);
          return;
        end
        CH_LBRK: begin
          put_token(K_LBRK, c, 1'b1);
          return;
        end
        CH_LPAR: begin
          put_token(K_LPAR, c, 1'b1);
          return;
        end
        CH_RPAR: begin
          put_token(K_RPAR, c, 1'b1);
          return;
        end
        CH_RBRK: begin
          put_token(K_RBRK, c, 1'b1);
          return;
        end
        default: ;
      endcase
      if (is_digit(c)) begin
        dig_buf[0] = c;
        dig_cnt = 1;
        lex = LX_DIGIT;
        return;
      end
    end
    if (c == CH_TICK) begin
      lex = LX_TICK1;
      return;
    end
    put_token(K_TEXT, c, 1'b1);
    lex = LX_TEXT;
  endfunction

  function automatic void extend_text(logic [7:0] c);
    logic stop;
    stop = (c == CH_NL) ||
           (!code_on && (c inside {CH_STAR, CH_LBRK, CH_RBRK, CH_LPAR, CH_RPAR}));
    if (stop) open_token(c);
    else put_token(K_TEXT, c, 1'b0);
  endfunction

  function automatic void classify(in_item_t req);
    logic [7:0] c;
    c = req.src_byte;
    step_q.delete();
    case (lex)
      LX_TEXT: extend_text(c);
      LX_STAR: begin
        if (c == CH_STAR) begin
          put_token(K_BOLD, CH_STAR, 1'b1);
          lex = LX_FRESH;
        end else begin
          put_token(K_ITALIC, CH_STAR, 1'b1);
          open_token(c);
        end
      end
      LX_TICK1: begin
        if (c == CH_TICK) begin
          lex = LX_TICK2;
        end else begin
          put_token(K_TEXT, CH_TICK, 1'b1);
          lex = LX_TEXT;
          extend_text(c);
        end
      end
      LX_TICK2: begin
        if (c == CH_TICK) begin
          put_token(K_FENCE, CH_TICK, 1'b1);
          code_on = !code_on;
          lex = LX_FRESH;
        end else begin
          put_token(K_TEXT, CH_TICK, 1'b1);
          put_token(K_TEXT, CH_TICK, 1'b0);
          lex = LX_TEXT;
          extend_text(c);
        end
      end
      LX_DIGIT: begin
        if (is_digit(c)) begin
          if (dig_cnt < MAX_DIGITS) begin
            dig_buf[dig_cnt] = c;
            dig_cnt++;
          end else begin
            flush_digits(K_TEXT);
            put_token(K_TEXT, c, 1'b0);
            lex = LX_LONG;
          end
        end else if (c == CH_DOT) begin
          flush_digits(K_OL);
          lex = LX_FRESH;
        end else begin
          flush_digits(K_TEXT);
          open_token(c);
        end
      end
      LX_LONG: begin
        if (is_digit(c)) put_token(K_TEXT, c, 1'b0);
        else open_token(c);
      end
      default: open_token(c);
    endcase
    if (req.end_of_source) begin
      case (lex)
        LX_STAR: put_token(K_ITALIC, CH_STAR, 1'b1);
        LX_TICK1: put_token(K_TEXT, CH_TICK, 1'b1);
        LX_TICK2: begin
          put_token(K_TEXT, CH_TICK, 1'b1);
          put_token(K_TEXT, CH_TICK, 1'b0);
        end
        LX_DIGIT: flush_digits(K_TEXT);
        default: ;
      endcase
      lex = LX_FRESH;
      code_on = 1'b0;
      dig_cnt = 0;
    end
  endfunction

  function automatic row_t plan_row(logic [7:0] b, logic eos, logic typed,
                                    logic [3:0] k, logic [7:0] tb, logic st);
    row_t r;
    r.req.src_byte = b;
    r.req.end_of_source = eos;
    r.typed = typed;
    r.want.token_kind = k;
    r.want.token_byte = tb;
    r.want.token_start = st;
    r.want.run_last = 1'b1;
    return r;
  endfunction

  task automatic plan_random(int n);
    logic [7:0] frag[$];
    int added;
    int len;
    logic eos;
    added = 0;
    while (added < n) begin
      frag.delete();
      case ($urandom_range(0, 9))
        0, 1: begin
          len = $urandom_range(1, 5);
          repeat (len) frag.push_back(8'($urandom_range(97, 122)));
          if ($urandom_range(0, 1) == 0) frag.push_back(8'h20);
        end
        2: frag.push_back(marks[$urandom_range(0, 6)]);
        3: begin
          repeat ($urandom_range(1, 3)) frag.push_back(CH_STAR);
          if ($urandom_range(0, 1) == 0) frag.push_back(8'($urandom_range(97, 122)));
        end
        4: begin
          repeat ($urandom_range(1, 2)) frag.push_back(CH_TICK);
          if ($urandom_range(0, 1) == 0) frag.push_back(8'($urandom_range(97, 122)));
          else frag.push_back(marks[$urandom_range(0, 6)]);
        end
        5: begin
          len = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 11) : $urandom_range(1, 8);
          repeat (len) frag.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
          if ($urandom_range(0, 2) == 0) frag.push_back(8'($urandom_range(0, 255)));
          else frag.push_back(CH_DOT);
        end
        6: frag.push_back(CH_NL);
        7: repeat ($urandom_range(1, 3)) frag.push_back(8'($urandom_range(0, 255)));
        8: begin
          repeat (3) frag.push_back(CH_TICK);
          repeat ($urandom_range(1, 4)) frag.push_back(marks[$urandom_range(0, 6)]);
          if ($urandom_range(0, 1) == 0) frag.push_back(CH_NL);
        end
        default: begin
          repeat ($urandom_range(1, 3)) frag.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
          frag.push_back(CH_DOT);
          frag.push_back(8'h20);
          frag.push_back(8'($urandom_range(65, 90)));
        end
      endcase
      eos = ($urandom_range(0, 11) == 0);
      foreach (frag[i]) begin
        plan_q.push_back(plan_row(frag[i], eos && (i == frag.size() - 1), 1'b0,
                                  K_TEXT, 8'h00, 1'b0));
      end
      added += frag.size();
    end
  endtask

  task automatic send_plan(int gap_pct);
    row_t r;
    while (plan_q.size() > 0) begin
      r = plan_q.pop_front();
      if ($urandom_range(0, 99) < gap_pct) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_data <= r.req;
      cur_row <= r;
      do @(posedge clk); while (in_stall);
    end
  endtask

  task automatic drain_tokens();
    in_valid <= 1'b0;
    @(posedge clk);
    while (token_q.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d tokens outstanding.",
               cycles, token_q.size());
      $display("CHECK FAILED");
      $finish;
    end else begin
      if (rst_n && in_valid && !in_stall) begin
        src_bytes++;
        if (cur_row.req.end_of_source) sources_ended++;
        classify(cur_row.req);
        if (cur_row.typed) begin
          token_q.push_back(cur_row.want);
        end else begin
          foreach (step_q[i]) begin
            tok = step_q[i];
            tok.run_last = (i == step_q.size() - 1);
            token_q.push_back(tok);
          end
        end
      end
      if (rst_n && out_valid && !out_stall) begin
        tokens_seen++;
        if (token_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Unexpected token at cycle %0d: kind %0d byte %02h start %0b last %0b",
                     cycles, out_data.token_kind, out_data.token_byte,
                     out_data.token_start, out_data.run_last);
          end
        end else begin
          want = token_q.pop_front();
          if (out_data !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("Token mismatch at cycle %0d: expected kind %0d byte %02h start %0b",
                       cycles, want.token_kind, want.token_byte, want.token_start);
              $display("  last %0b, got kind %0d byte %02h start %0b last %0b",
                       want.run_last, out_data.token_kind, out_data.token_byte,
                       out_data.token_start, out_data.run_last);
            end
          end
        end
      end
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    plan_q.push_back(plan_row(CH_HASH, 1'b0, 1'b1, K_HEADING, CH_HASH, 1'b1));
    plan_q.push_back(plan_row(CH_DASH, 1'b0, 1'b1, K_UL, CH_DASH, 1'b1));
    plan_q.push_back(plan_row(CH_BANG, 1'b0, 1'b1, K_IMAGE, CH_BANG, 1'b1));
    plan_q.push_back(plan_row(CH_LBRK, 1'b0, 1'b1, K_LBRK, CH_LBRK, 1'b1));
    plan_q.push_back(plan_row(CH_RBRK, 1'b0, 1'b1, K_RBRK, CH_RBRK, 1'b1));
    plan_q.push_back(plan_row(CH_LPAR, 1'b0, 1'b1, K_LPAR, CH_LPAR, 1'b1));
    plan_q.push_back(plan_row(CH_RPAR, 1'b0, 1'b1, K_RPAR, CH_RPAR, 1'b1));
    plan_q.push_back(plan_row(CH_NL, 1'b0, 1'b1, K_LINEBREAK, CH_NL, 1'b1));
    plan_q.push_back(plan_row(CH_STAR, 1'b0, 1'b0, K_TEXT, 8'h00, 1'b0));
    plan_q.push_back(plan_row(CH_STAR, 1'b0, 1'b1, K_BOLD, CH_STAR, 1'b1));
    plan_q.push_back(plan_row(CH_STAR, 1'b1, 1'b1, K_ITALIC, CH_STAR, 1'b1));
    plan_q.push_back(plan_row(8'h00, 1'b0, 1'b1, K_TEXT, 8'h00, 1'b1));
    plan_q.push_back(plan_row(8'hFF, 1'b1, 1'b1, K_TEXT, 8'hFF, 1'b0));
    plan_q.push_back(plan_row(8'h37, 1'b0, 1'b0, K_TEXT, 8'h00, 1'b0));
    plan_q.push_back(plan_row(CH_DOT, 1'b0, 1'b1, K_OL, 8'h37, 1'b1));
    plan_q.push_back(plan_row(CH_TICK, 1'b0, 1'b0, K_TEXT, 8'h00, 1'b0));
    plan_q.push_back(plan_row(CH_TICK, 1'b0, 1'b0, K_TEXT, 8'h00, 1'b0));
    plan_q.push_back(plan_row(CH_TICK, 1'b0, 1'b1, K_FENCE, CH_TICK, 1'b1));
    plan_q.push_back(plan_row(CH_LPAR, 1'b0, 1'b0, K_TEXT, 8'h00, 1'b0));
    plan_q.push_back(plan_row(CH_NL, 1'b0, 1'b1, K_LINEBREAK, CH_NL, 1'b1));
    plan_q.push_back(plan_row(CH_TICK, 1'b0, 1'b0, K_TEXT, 8'h00, 1'b0));
    plan_q.push_back(plan_row(CH_TICK, 1'b0, 1'b0, K_TEXT, 8'h00, 1'b0));
    plan_q.push_back(plan_row(CH_TICK, 1'b0, 1'b1, K_FENCE, CH_TICK, 1'b1));
    plan_q.push_back(plan_row(CH_TICK, 1'b1, 1'b1, K_TEXT, CH_TICK, 1'b1));
    plan_q.push_back(plan_row(8'h39, 1'b1, 1'b1, K_TEXT, 8'h39, 1'b1));

    stall_pct = 71;
    send_plan(9);
    plan_random(45);
    send_plan(9);
    drain_tokens();

    stall_pct = 9;
    plan_random(45);
    send_plan(71);

    stall_pct = 0;
    plan_random(45);
    send_plan(0);
    drain_tokens();
    repeat (20) @(posedge clk);

    $display("Run covered %0d source bytes, %0d of them ending a source, and %0d tokens,",
             src_bytes, sources_ended, tokens_seen);
    $display("over delimiters, fences, digit runs and three pacing mixes; %0d mismatches.",
             mismatches);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/mtc_pkg.sv
design/mtc_ctrl.sv
design/mtc_datapath.sv
design/markdown_token_classifier_core.sv
verif/tb_markdown_token_classifier_core.sv
